>>> sv/sbb_pkg.sv
// sbb_pkg: shared constants, codes and types of the separable box blur.
// No dependencies; every other file of the block imports it.
`default_nettype none

package sbb_pkg;

    // default geometry
    localparam int RADIUS_DEF     = 2;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    // fixed field widths
    localparam int FIELD_PIX_W = 16;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 1;

    // register reset values
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 1024;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // result queue
    localparam int OQ_DEPTH = 8;
    localparam int PEND_W   = $clog2(OQ_DEPTH + 1);
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // per-item control, decided at acceptance
    typedef struct packed {
        logic pix;      // pixel item accepted
        logic push;     // raw pixel goes into the delay store
        logic emit;     // item produces a result
        logic blur;     // result is the filtered value
        logic wr_h;     // horizontal mean is written to the line store
        logic hrow_ok;  // horizontal mean row lies in the interior
        logic last;     // result is the last pixel of the frame
    } t_ctl;

endpackage

`default_nettype wire

>>> sv/separable_box_blur.sv
// separable_box_blur: top level of the streaming separable box blur.
// Uses sbb_pkg, sbb_ctrl, sbb_datapath and sbb_out_queue.
`default_nettype none

// Takes one item per clock while ready is high (pixel or flush) in raster order
// and returns the blurred frame in the same order. A result trails its input by
// RADIUS*frame_width + RADIUS pixel items; after the last pixel of a frame, send
// that many flush items (at the start of the next frame) to drain the tail. Once
// accepted, an item is written into the output queue after the register stages
// below and can leave on the clock after that: the delay and line store reads,
// the two window sums, the horizontal mean multiply and the column total are
// each one register stage, and the vertical mean multiply feeds the queue
// directly. The queue holds 8 results; ready drops only while 8 results are
// accepted but not yet taken. Writing frame_width or frame_height restarts the
// stream and drops pending pixels; write them only while the block is idle. No
// clearing pass is needed after reset.
module separable_box_blur import sbb_pkg::*; #(
    parameter int RADIUS     = RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_cmd,
    input  wire logic [FIELD_PIX_W-1:0] i_pixel_in,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [FIELD_PIX_W-1:0]      o_pixel_out,
    output logic                        o_frame_end
);

    localparam int CAP    = RADIUS * MAX_WIDTH + RADIUS;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int RAW_AW = $clog2(CAP);
    localparam int SLOT_W = $clog2(2 * RADIUS);

    t_ctl                   ctl;
    logic [SLOT_W-1:0]      slot;
    logic [COL_W-1:0]       hcol;
    logic [RAW_AW-1:0]      raw_wr_addr;
    logic [RAW_AW-1:0]      raw_rd_addr;
    logic                   res_valid;
    logic [FIELD_PIX_W-1:0] res_pixel;
    logic                   res_last;

    sbb_ctrl #(
        .RADIUS    (RADIUS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_cmd         (i_cmd),
        .o_in_ready    (o_in_ready),
        .i_out_acc     (o_out_valid && i_out_ready),
        .o_ctl         (ctl),
        .o_slot        (slot),
        .o_hcol        (hcol),
        .o_raw_wr_addr (raw_wr_addr),
        .o_raw_rd_addr (raw_rd_addr)
    );

    sbb_datapath #(
        .RADIUS     (RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_slot        (slot),
        .i_hcol        (hcol),
        .i_raw_wr_addr (raw_wr_addr),
        .i_raw_rd_addr (raw_rd_addr),
        .i_pixel_in    (i_pixel_in),
        .o_res_valid   (res_valid),
        .o_res_pixel   (res_pixel),
        .o_res_last    (res_last)
    );

    sbb_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_pixel (res_pixel),
        .i_last  (res_last),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_pixel (o_pixel_out),
        .o_last  (o_frame_end)
    );

endmodule

`default_nettype wire

>>> sv/sbb_ctrl.sv
// sbb_ctrl: frame registers, raster position counters, raw delay pointers
// and result credits of the box blur. Uses sbb_pkg.
`default_nettype none

module sbb_ctrl import sbb_pkg::*; #(
    parameter int RADIUS    = RADIUS_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]                   i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]                   i_cfg_data,
    input  wire logic                                    i_in_valid,
    input  wire logic                                    i_cmd,
    output logic                                         o_in_ready,
    input  wire logic                                    i_out_acc,
    output t_ctl                                         o_ctl,
    output logic [$clog2(2*RADIUS)-1:0]                  o_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]                 o_hcol,
    output logic [$clog2(RADIUS*MAX_WIDTH+RADIUS)-1:0]   o_raw_wr_addr,
    output logic [$clog2(RADIUS*MAX_WIDTH+RADIUS)-1:0]   o_raw_rd_addr
);

    localparam int LROWS  = 2 * RADIUS;
    localparam int CAP    = RADIUS * MAX_WIDTH + RADIUS;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W  = $clog2(CAP + 1);
    localparam int RAW_AW = $clog2(CAP);
    localparam int SLOT_W = $clog2(LROWS);
    localparam int W_RST  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [WID_W-1:0]    r_width,   n_width;
    logic [HEIGHT_W-1:0] r_height,  n_height;
    logic [COL_W-1:0]    r_in_col,  n_in_col;
    logic [HEIGHT_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic [HEIGHT_W-1:0] r_out_row, n_out_row;
    logic [SLOT_W-1:0]   r_slot,    n_slot;
    logic [RAW_AW-1:0]   r_head,    n_head;
    logic [RAW_AW-1:0]   r_tail,    n_tail;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [PEND_W-1:0]   r_pend,    n_pend;

    logic                   acc;
    logic                   pix_item;
    logic [CNT_W-1:0]       lag;
    logic                   emit_flush;
    logic                   emit_pix;
    logic                   emit;
    logic                   have_h;
    logic                   hrow_ok;
    logic                   out_int;
    logic                   last;
    logic                   push;
    logic                   restart;
    logic [WIDTH_REG_W-1:0] wr_width;

    assign o_in_ready = (32'(r_pend) < OQ_DEPTH);
    assign acc        = i_in_valid && o_in_ready;
    assign pix_item   = (i_cmd == CMD_PIXEL);

    assign lag        = CNT_W'(RADIUS) * CNT_W'(r_width) + CNT_W'(RADIUS);
    assign emit_flush = (r_in_col == '0) && (r_in_row == '0) && (r_count != '0);
    assign emit_pix   = (r_count >= lag);
    assign emit       = pix_item ? emit_pix : emit_flush;

    assign have_h  = 32'(r_in_col) >= 32'(2 * RADIUS);
    assign hrow_ok = (32'(r_in_row) >= 32'(RADIUS)) &&
                     (32'(r_in_row) + 32'(RADIUS) < 32'(r_height));
    assign out_int = (32'(r_out_row) >= 32'(RADIUS)) &&
                     (32'(r_out_row) + 32'(RADIUS) < 32'(r_height)) &&
                     (32'(r_out_col) >= 32'(RADIUS)) &&
                     (32'(r_out_col) + 32'(RADIUS) < 32'(r_width));
    assign last    = (32'(r_out_row) + 32'd1 == 32'(r_height)) &&
                     (32'(r_out_col) + 32'd1 == 32'(r_width));
    // the store is never over full; a pop frees the slot when count is at capacity
    assign push    = pix_item && (emit_pix || (32'(r_count) < CAP));

    assign o_ctl.pix     = acc && pix_item;
    assign o_ctl.push    = acc && push;
    assign o_ctl.emit    = acc && emit;
    assign o_ctl.blur    = acc && pix_item && emit_pix && have_h && out_int;
    assign o_ctl.wr_h    = acc && pix_item && have_h;
    assign o_ctl.hrow_ok = hrow_ok;
    assign o_ctl.last    = last;

    assign o_slot        = r_slot;
    assign o_hcol        = have_h ? COL_W'(32'(r_in_col) - 32'(RADIUS)) : '0;
    assign o_raw_wr_addr = r_tail;
    assign o_raw_rd_addr = r_head;

    assign wr_width = i_cfg_data[WIDTH_REG_W-1:0];

    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_slot    = r_slot;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        restart   = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRAME_WIDTH: begin
                    if (wr_width == '0) begin
                        n_width = WID_W'(1);
                    end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
                        n_width = WID_W'(MAX_WIDTH);
                    end else begin
                        n_width = WID_W'(wr_width);
                    end
                    restart = 1'b1;
                end
                CFG_FRAME_HEIGHT: begin
                    n_height = (i_cfg_data == '0) ? HEIGHT_W'(1) : i_cfg_data;
                    restart  = 1'b1;
                end
                default: ;
            endcase
            if (restart) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_slot    = '0;
                n_head    = '0;
                n_tail    = '0;
                n_count   = '0;
            end
        end else if (acc) begin
            if (pix_item) begin
                if (32'(r_in_col) + 32'd1 >= 32'(r_width)) begin
                    n_in_col = '0;
                    if (32'(r_in_row) + 32'd1 >= 32'(r_height)) begin
                        n_in_row = '0;
                        n_slot   = '0;
                    end else begin
                        n_in_row = r_in_row + 1'b1;
                        n_slot   = (32'(r_slot) == LROWS - 1) ? '0 : r_slot + 1'b1;
                    end
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
            end
            if (emit) begin
                if (32'(r_out_col) + 32'd1 >= 32'(r_width)) begin
                    n_out_col = '0;
                    n_out_row = (32'(r_out_row) + 32'd1 >= 32'(r_height)) ?
                                '0 : r_out_row + 1'b1;
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
                n_head = (32'(r_head) == CAP - 1) ? '0 : r_head + 1'b1;
            end
            if (push) begin
                n_tail = (32'(r_tail) == CAP - 1) ? '0 : r_tail + 1'b1;
            end
            n_count = r_count + CNT_W'(push) - CNT_W'(emit);
        end
    end

    assign n_pend = r_pend + PEND_W'(acc && emit) - PEND_W'(i_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WID_W'(W_RST);
            r_height  <= HEIGHT_W'(HEIGHT_RESET);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_slot    <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_pend    <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_slot    <= n_slot;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_pend    <= n_pend;
        end
    end

endmodule

`default_nettype wire

>>> sv/sbb_datapath.sv
// sbb_datapath: row window, raw delay store, line store of horizontal means
// and the four-stage arithmetic pipeline of the box blur. Uses sbb_pkg.
`default_nettype none

module sbb_datapath import sbb_pkg::*; #(
    parameter int RADIUS     = RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire t_ctl                                       i_ctl,
    input  wire logic [$clog2(2*RADIUS)-1:0]                i_slot,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]               i_hcol,
    input  wire logic [$clog2(RADIUS*MAX_WIDTH+RADIUS)-1:0] i_raw_wr_addr,
    input  wire logic [$clog2(RADIUS*MAX_WIDTH+RADIUS)-1:0] i_raw_rd_addr,
    input  wire logic [FIELD_PIX_W-1:0]                     i_pixel_in,
    output logic                                            o_res_valid,
    output logic [FIELD_PIX_W-1:0]                          o_res_pixel,
    output logic                                            o_res_last
);

    localparam int PW      = (PIXEL_BITS < FIELD_PIX_W) ? PIXEL_BITS : FIELD_PIX_W;
    localparam int WIN     = 2 * RADIUS + 1;
    localparam int LROWS   = 2 * RADIUS;
    localparam int CAP     = RADIUS * MAX_WIDTH + RADIUS;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int RAW_AW  = $clog2(CAP);
    localparam int SLOT_W  = $clog2(LROWS);
    localparam int SUM_W   = PW + $clog2(WIN);
    // floor(x / WIN) = (x * RECIP) >> K_SH, exact for every x below 2**SUM_W
    localparam int K_SH    = SUM_W + $clog2(WIN);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP = ((64'd1 << K_SH) + 64'(WIN) - 64'd1) / 64'(WIN);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    logic [PW-1:0] px;
    logic [PW-1:0] r_win [WIN];
    logic [PW-1:0] raw_mem [CAP];
    logic [PW-1:0] r_raw_q;
    logic [PW-1:0] r_bank_q [LROWS];

    // stage 1: memory read data, window complete
    t_ctl              r_s1_ctl;
    logic [SLOT_W-1:0] r_s1_slot;
    logic [COL_W-1:0]  r_s1_hcol;
    logic [SUM_W-1:0]  hsum;
    logic [SUM_W-1:0]  vsum;

    // stage 2: horizontal mean, line store write
    t_ctl              r_s2_ctl;
    logic [SLOT_W-1:0] r_s2_slot;
    logic [COL_W-1:0]  r_s2_hcol;
    logic [SUM_W-1:0]  r_s2_hsum;
    logic [SUM_W-1:0]  r_s2_vsum;
    logic [PW-1:0]     r_s2_raw;
    logic [PROD_W-1:0] hprod;
    logic [PW-1:0]     hval;

    // stage 3: column sum
    t_ctl              r_s3_ctl;
    logic [PW-1:0]     r_s3_hval;
    logic [SUM_W-1:0]  r_s3_vsum;
    logic [PW-1:0]     r_s3_raw;

    // stage 4: vertical mean
    t_ctl              r_s4_ctl;
    logic [SUM_W-1:0]  r_s4_tot;
    logic [PW-1:0]     r_s4_raw;
    logic [PROD_W-1:0] vprod;
    logic [PW-1:0]     vmean;

    assign px = i_pixel_in[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.pix) begin
            for (int k = 0; k < WIN - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[WIN-1] <= px;
        end
    end

    // raw delay store: read before write, so a pop and a push at one address work
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            raw_mem[i_raw_wr_addr] <= px;
        end
        r_raw_q <= raw_mem[i_raw_rd_addr];
    end

    // one bank per row slot; all banks are read at the column, one is written
    for (genvar b = 0; b < LROWS; b++) begin : g_bank
        logic [PW-1:0] line_mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (r_s2_ctl.wr_h && (r_s2_slot == SLOT_W'(b))) begin
                line_mem[r_s2_hcol] <= hval;
            end
            r_bank_q[b] <= line_mem[i_hcol];
        end
    end

    always_comb begin
        hsum = '0;
        for (int k = 0; k < WIN; k++) begin
            hsum = hsum + SUM_W'(r_win[k]);
        end
    end

    always_comb begin
        vsum = '0;
        for (int k = 0; k < LROWS; k++) begin
            vsum = vsum + SUM_W'(r_bank_q[k]);
        end
    end

    assign hprod = PROD_W'(r_s2_hsum) * PROD_W'(RECIP_C);
    // rows near the top and bottom edge contribute zero
    assign hval  = r_s2_ctl.hrow_ok ? PW'(hprod >> K_SH) : '0;

    assign vprod = PROD_W'(r_s4_tot) * PROD_W'(RECIP_C);
    assign vmean = PW'(vprod >> K_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
            r_s4_ctl <= '0;
        end else begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
            r_s4_ctl <= r_s3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_slot <= i_slot;
        r_s1_hcol <= i_hcol;

        r_s2_slot <= r_s1_slot;
        r_s2_hcol <= r_s1_hcol;
        r_s2_hsum <= hsum;
        r_s2_vsum <= vsum;
        r_s2_raw  <= r_raw_q;

        r_s3_hval <= hval;
        r_s3_vsum <= r_s2_vsum;
        r_s3_raw  <= r_s2_raw;

        r_s4_tot  <= SUM_W'(r_s3_hval) + r_s3_vsum;
        r_s4_raw  <= r_s3_raw;
    end

    assign o_res_valid = r_s4_ctl.emit;
    assign o_res_pixel = FIELD_PIX_W'(r_s4_ctl.blur ? vmean : r_s4_raw);
    assign o_res_last  = r_s4_ctl.last;

endmodule

`default_nettype wire

>>> sv/sbb_out_queue.sv
// sbb_out_queue: small result queue in front of the output channel.
// Uses sbb_pkg for its depth; space is guaranteed by the credit count in sbb_ctrl.
`default_nettype none

module sbb_out_queue import sbb_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_wr,
    input  wire logic [FIELD_PIX_W-1:0] i_pixel,
    input  wire logic                   i_last,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [FIELD_PIX_W-1:0]      o_pixel,
    output logic                        o_last
);

    logic [FIELD_PIX_W:0] r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]     r_wr_ptr;
    logic [OQ_AW-1:0]     r_rd_ptr;
    logic [PEND_W-1:0]    r_cnt;
    logic                 rd;

    assign o_valid = (r_cnt != '0);
    assign rd      = o_valid && i_ready;
    assign o_pixel = r_mem[r_rd_ptr][FIELD_PIX_W-1:0];
    assign o_last  = r_mem[r_rd_ptr][FIELD_PIX_W];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= {i_last, i_pixel};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (32'(r_wr_ptr) == OQ_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (32'(r_rd_ptr) == OQ_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + PEND_W'(i_wr) - PEND_W'(rd);
        end
    end

endmodule

`default_nettype wire

>>> sv/sbb_checker.sv
// sbb_checker: port-level assertions for separable_box_blur, bound to the top.
// Uses sbb_pkg for port widths.
`default_nettype none

module sbb_checker import sbb_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_in_ready,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [FIELD_PIX_W-1:0] o_pixel_out,
    input wire logic                   o_frame_end
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_pixel_out) && $stable(o_frame_end))
        else $error("result changed while stalled");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // credits run out only when results are queued at the output
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind separable_box_blur sbb_checker u_sbb_checker (.*);

`default_nettype wire
